// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dldt_pkg.sv =====
package dldt_pkg;

   localparam int COUNT_WIDTH     = 17;
   localparam int HOLD_WIDTH      = 3;
   localparam int PRESS_WIDTH     = HOLD_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = COUNT_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ON_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS = 2'd2;

   localparam logic [COUNT_WIDTH-1:0] ON_TICKS_RESET   = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] OFF_TICKS_RESET  = COUNT_WIDTH'(1);
   localparam logic [HOLD_WIDTH-1:0]  HOLD_TICKS_RESET = HOLD_WIDTH'(3);

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] on_ticks;
      logic [COUNT_WIDTH-1:0] off_ticks;
      logic [HOLD_WIDTH-1:0]  hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic button_pressed;
      logic is_dark;
   } req_type;

   typedef struct packed {
      logic power_indicator;
      logic lamp;
   } rsp_type;

endpackage

// ===== sv/dldt_core.sv =====
module dldt_core (
   input  logic              clock,
   input  logic              reset,
   input  dldt_pkg::cfg_type cfg,
   input  logic              step,
   input  dldt_pkg::req_type req,
   output dldt_pkg::rsp_type rsp
);

   logic                             power_ff, power_in;
   logic                             lamp_ff, lamp_in;
   logic [dldt_pkg::COUNT_WIDTH-1:0] on_rem_ff, on_rem_in;
   logic [dldt_pkg::COUNT_WIDTH-1:0] off_rem_ff, off_rem_in;
   logic [dldt_pkg::PRESS_WIDTH-1:0] press_ff, press_in;
   logic [dldt_pkg::PRESS_WIDTH-1:0] hold_ext;

   assign hold_ext = {1'b0, cfg.hold_ticks};

   always_comb begin
      power_in   = power_ff;
      lamp_in    = lamp_ff;
      on_rem_in  = on_rem_ff;
      off_rem_in = off_rem_ff;
      press_in   = press_ff;

      if (power_ff) begin
         if (on_rem_ff != '0) begin
            lamp_in   = 1'b1;
            on_rem_in = on_rem_ff - 1'b1;
         end else if (off_rem_ff != '0) begin
            lamp_in    = 1'b0;
            off_rem_in = off_rem_ff - 1'b1;
         end else begin
            on_rem_in  = cfg.on_ticks;
            off_rem_in = cfg.off_ticks;
         end
      end

      if (req.button_pressed) begin
         if (press_ff < hold_ext) begin
            press_in = press_ff + 1'b1;
         end else if (press_ff == hold_ext) begin
            press_in = press_ff + 1'b1;
            if (!power_ff) begin
               power_in   = 1'b1;
               on_rem_in  = cfg.on_ticks;
               off_rem_in = cfg.off_ticks;
            end else begin
               power_in   = 1'b0;
               lamp_in    = 1'b0;
               on_rem_in  = '0;
               off_rem_in = '0;
            end
         end
      end else begin
         press_in = '0;
      end

      if (req.is_dark) begin
         if (power_in) begin
            lamp_in = (on_rem_in != '0);
         end
      end else begin
         lamp_in = 1'b0;
      end

      rsp.power_indicator = power_ff;
      rsp.lamp            = lamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff   <= 1'b0;
         lamp_ff    <= 1'b0;
         on_rem_ff  <= '0;
         off_rem_ff <= '0;
         press_ff   <= '0;
      end else if (step) begin
         power_ff   <= power_in;
         lamp_ff    <= lamp_in;
         on_rem_ff  <= on_rem_in;
         off_rem_ff <= off_rem_in;
         press_ff   <= press_in;
      end
   end

endmodule

// ===== sv/dusk_lamp_duty_timer.sv =====
// An accepted word's result is written into the result queue, so rsp_valid is high in the cycle after the accept.
// Throughput: one word per cycle unless stalled; tick state steps once per accept.
// A two-entry result queue lets input words enter while a result waits to be taken.
// req_stall is high only when both queue entries are occupied.
// Synchronous active-high reset clears the tick state and the queue and sets the
// registers to on_ticks 1, off_ticks 1 and hold_ticks 3.
module dusk_lamp_duty_timer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dldt_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dldt_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [dldt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dldt_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   dldt_pkg::cfg_type cfg_ff, cfg_in;
   dldt_pkg::rsp_type step_rsp;
   dldt_pkg::rsp_type queue_ff [2];
   dldt_pkg::rsp_type queue_in [2];
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;

   assign req_stall = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = queue_ff[0];
   assign push      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            dldt_pkg::CSR_ON_TICKS:   cfg_in.on_ticks   = csr_data[dldt_pkg::COUNT_WIDTH-1:0];
            dldt_pkg::CSR_OFF_TICKS:  cfg_in.off_ticks  = csr_data[dldt_pkg::COUNT_WIDTH-1:0];
            dldt_pkg::CSR_HOLD_TICKS: cfg_in.hold_ticks = csr_data[dldt_pkg::HOLD_WIDTH-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   dldt_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .step  (push),
      .req   (req_data),
      .rsp   (step_rsp)
   );

   always_comb begin
      queue_in[0] = queue_ff[0];
      queue_in[1] = queue_ff[1];
      count_in    = count_ff;
      if (push && pop) begin
         queue_in[0] = step_rsp;
      end else if (pop) begin
         queue_in[0] = queue_ff[1];
         count_in    = count_ff - 2'd1;
      end else if (push) begin
         queue_in[count_ff[0]] = step_rsp;
         count_in              = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff          <= 2'd0;
         cfg_ff.on_ticks   <= dldt_pkg::ON_TICKS_RESET;
         cfg_ff.off_ticks  <= dldt_pkg::OFF_TICKS_RESET;
         cfg_ff.hold_ticks <= dldt_pkg::HOLD_TICKS_RESET;
      end else begin
         count_ff <= count_in;
         cfg_ff   <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff[0] <= queue_in[0];
      queue_ff[1] <= queue_in[1];
   end

endmodule

// ===== sv/dldt_checker.sv =====
`include "assert_macros.svh"

module dldt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dldt_pkg::rsp_type rsp_data
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result word changed or dropped")
   `ASSERT_NEXT(a_accept_result, clock, reset, req_valid && !req_stall, rsp_valid, "accepted word gave no result in the next cycle")
   `ASSERT_IMPL(a_stall_needs_result, clock, reset, req_stall, rsp_valid, "input stalled with no result waiting")
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall, "result queue not empty after reset")

endmodule

bind dusk_lamp_duty_timer dldt_checker u_dldt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
